// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/ppr_pkg.sv
// Package: types, widths and helpers of the perspective projection pipeline.
package ppr_pkg;

  localparam int CoordW = 32;
  localparam int CamW   = CoordW + 1;       // camera-space coordinate
  localparam int SizeW  = 13;
  localparam int PixW   = 16;
  localparam int DepthW = CoordW;           // positive depth magnitude
  localparam int DenW   = DepthW + 1;       // 2 * depth
  localparam int ProdW  = CamW + SizeW + 1; // signed coordinate * side
  localparam int SzProdW = SizeW + DepthW;  // side * depth
  localparam int NumW   = 51;               // biased numerator, signed
  localparam int RemW   = NumW - 2;         // remainder once in range
  localparam int IdxW   = 3;

  localparam logic signed [PixW-1:0] PixMin = {1'b1, {(PixW-1){1'b0}}};
  localparam logic signed [PixW-1:0] PixMax = {1'b0, {(PixW-1){1'b1}}};

  typedef enum logic [IdxW-1:0] {
    REG_CAM_X  = 3'd0,
    REG_CAM_Y  = 3'd1,
    REG_CAM_Z  = 3'd2,
    REG_IMG_W  = 3'd3,
    REG_IMG_H  = 3'd4
  } ppr_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] world_x;
    logic signed [CoordW-1:0] world_y;
    logic signed [CoordW-1:0] world_z;
  } ppr_point_t;

  typedef struct packed {
    logic signed [PixW-1:0] pixel_x;
    logic signed [PixW-1:0] pixel_y;
    logic                   behind_camera;
    logic                   saturated;
  } ppr_pixel_t;

  typedef struct packed {
    logic [IdxW-1:0]   index;
    logic [CoordW-1:0] data;
  } ppr_cfg_t;

  // numerators biased by 2^15 * den, ready for division
  typedef struct packed {
    logic                    behind;
    logic signed [NumW-1:0]  nx;
    logic signed [NumW-1:0]  ny;
    logic [DenW-1:0]         den;
  } ppr_num_t;

  typedef struct packed {
    logic               behind;
    logic               lo_x;
    logic               hi_x;
    logic               lo_y;
    logic               hi_y;
    logic [RemW-1:0]    rx;
    logic [RemW-1:0]    ry;
    logic [PixW-1:0]    qx;
    logic [PixW-1:0]    qy;
    logic [DenW-1:0]    den;
  } ppr_div_t;

  // one restoring step: remainder against den shifted up by sh
  function automatic logic [RemW:0] ppr_step(logic [RemW-1:0] r, logic [DenW-1:0] den,
                                             int unsigned sh);
    logic [RemW-1:0] trial;
    logic            ge;
    trial = RemW'(den) << sh;
    ge    = (r >= trial);
    return {ge, ge ? (r - trial) : r};
  endfunction

endpackage

// File: rtl/core/ppr_if.sv
// Stream interfaces: point words in, pixel words out, register writes.
interface ppr_point_if;
  logic                valid;
  logic                ready;
  ppr_pkg::ppr_point_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppr_pixel_if;
  logic                valid;
  logic                ready;
  ppr_pkg::ppr_pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppr_cfg_if;
  logic              valid;
  logic              ready;
  ppr_pkg::ppr_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/ppr_divider.sv
// Pipelined floor divider: range check stage, then one quotient bit per stage, two lanes.
`include "assert_macros.svh"
module ppr_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ppr_pkg::ppr_num_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ppr_pkg::ppr_div_t out_data_o
);
  import ppr_pkg::*;

  localparam int Stages = PixW + 1;

  logic     v_q   [Stages];
  ppr_div_t d_q   [Stages];
  logic     rdy   [Stages+1];
  ppr_div_t d_d   [Stages];

  logic signed [NumW-1:0] lim;

  always_comb begin
    rdy[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  // range check: biased numerator must lie in [0, 2^16 * den)
  always_comb begin
    lim           = NumW'(in_data_i.den) << PixW;
    d_d[0].behind = in_data_i.behind;
    d_d[0].lo_x   = in_data_i.nx[NumW-1];
    d_d[0].hi_x   = !in_data_i.nx[NumW-1] && (in_data_i.nx >= lim);
    d_d[0].lo_y   = in_data_i.ny[NumW-1];
    d_d[0].hi_y   = !in_data_i.ny[NumW-1] && (in_data_i.ny >= lim);
    d_d[0].rx     = in_data_i.nx[RemW-1:0];
    d_d[0].ry     = in_data_i.ny[RemW-1:0];
    d_d[0].qx     = '0;
    d_d[0].qy     = '0;
    d_d[0].den    = in_data_i.den;
  end

  for (genvar k = 1; k < Stages; k++) begin : g_step
    logic [RemW:0] sx;
    logic [RemW:0] sy;
    always_comb begin
      sx               = ppr_step(d_q[k-1].rx, d_q[k-1].den, Stages - 1 - k);
      sy               = ppr_step(d_q[k-1].ry, d_q[k-1].den, Stages - 1 - k);
      d_d[k]           = d_q[k-1];
      d_d[k].rx        = sx[RemW-1:0];
      d_d[k].ry        = sy[RemW-1:0];
      d_d[k].qx[Stages-1-k] = sx[RemW];
      d_d[k].qy[Stages-1-k] = sy[RemW];
    end
  end

  for (genvar k = 0; k < Stages; k++) begin : g_reg
    logic pv;
    if (k == 0) begin : g_first
      assign pv = in_valid_i;
    end else begin : g_rest
      assign pv = v_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= pv;
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[k] && pv) begin
        d_q[k] <= d_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Stages-1];
  assign out_data_o  = d_q[Stages-1];

  // finished remainder must sit below the divisor
  `ASSERT_IMPL(a_rem_x, clk_i, rst_ni,
    out_valid_o && !out_data_o.lo_x && !out_data_o.hi_x,
    out_data_o.rx < RemW'(out_data_o.den))
  `ASSERT_IMPL(a_rem_y, clk_i, rst_ni,
    out_valid_o && !out_data_o.lo_y && !out_data_o.hi_y,
    out_data_o.ry < RemW'(out_data_o.den))
  `ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid_o,
    !(out_data_o.lo_x && out_data_o.hi_x) && !(out_data_o.lo_y && out_data_o.hi_y))
endmodule

// File: rtl/core/perspective_point_to_raster.sv
// Top level: pinhole projection of world points onto raster pixel coordinates.
// Pipeline from an accepted point word to its pixel word: 3 front stages,
// range check, 16 one-bit division stages, output register.
// Throughput: one word per cycle while px_out is ready; the divider's 16 restoring stages set the depth.
// Reset: camera at origin, image 640 x 480, pipeline empty; rst_ni is async.
`include "assert_macros.svh"
module perspective_point_to_raster (
  input  logic  clk_i,
  input  logic  rst_ni,
  ppr_point_if.sink   pt_in,
  ppr_pixel_if.source px_out,
  ppr_cfg_if.sink     cfg
);
  import ppr_pkg::*;

  // configuration registers, always writable
  logic signed [CoordW-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [SizeW-1:0]         img_w_q, img_h_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      img_w_q <= SizeW'(640);
      img_h_q <= SizeW'(480);
    end else if (cfg.valid) begin
      case (ppr_reg_e'(cfg.data.index))
        REG_CAM_X: cam_x_q <= cfg.data.data;
        REG_CAM_Y: cam_y_q <= cfg.data.data;
        REG_CAM_Z: cam_z_q <= cfg.data.data;
        REG_IMG_W: img_w_q <= cfg.data.data[SizeW-1:0];
        REG_IMG_H: img_h_q <= cfg.data.data[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // ready chain: a stage moves when empty or when its successor moves
  logic rdy1, rdy2, rdy3, div_rdy, rdy_out;

  // stage 1: camera-space translation, depth sign
  logic                     s1_v_q;
  logic signed [CamW-1:0]   s1_cx_q, s1_cy_q;
  logic [DepthW-1:0]        s1_d_q;
  logic                     s1_behind_q;
  logic [SizeW-1:0]         s1_w_q, s1_h_q, s1_m_q;
  logic signed [CamW-1:0]   cz;
  logic signed [CamW-1:0]   dz;

  always_comb begin
    cz = CamW'(pt_in.data.world_z) - CamW'(cam_z_q);
    dz = -cz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (rdy1) begin
      s1_v_q <= pt_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && pt_in.valid) begin
      s1_cx_q     <= CamW'(pt_in.data.world_x) - CamW'(cam_x_q);
      s1_cy_q     <= CamW'(pt_in.data.world_y) - CamW'(cam_y_q);
      s1_d_q      <= dz[DepthW-1:0];
      // depth zero or negative: cz not negative
      s1_behind_q <= !cz[CamW-1];
      s1_w_q      <= img_w_q;
      s1_h_q      <= img_h_q;
      s1_m_q      <= (img_w_q < img_h_q) ? img_w_q : img_h_q;
    end
  end

  // stage 2: products
  logic                     s2_v_q;
  logic signed [ProdW-1:0]  s2_xm_q, s2_ym_q;
  logic [SzProdW-1:0]       s2_wd_q, s2_hd_q;
  logic [DepthW-1:0]        s2_d_q;
  logic                     s2_behind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (rdy2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_v_q) begin
      s2_xm_q     <= ProdW'(s1_cx_q * $signed({1'b0, s1_m_q}));
      s2_ym_q     <= ProdW'(s1_cy_q * $signed({1'b0, s1_m_q}));
      s2_wd_q     <= SzProdW'(s1_w_q * s1_d_q);
      s2_hd_q     <= SzProdW'(s1_h_q * s1_d_q);
      s2_d_q      <= s1_d_q;
      s2_behind_q <= s1_behind_q;
    end
  end

  // stage 3: numerators over den = 2d, biased by 2^15 * den so the
  // floored quotient becomes unsigned
  logic     s3_v_q;
  ppr_num_t s3_q;
  logic signed [NumW-1:0] bias;

  assign bias = NumW'({s2_d_q, 16'd0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (rdy3) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_v_q) begin
      s3_q.behind <= s2_behind_q;
      s3_q.nx     <= (NumW'(s2_xm_q) <<< 1) + NumW'(s2_wd_q) + bias;
      s3_q.ny     <= NumW'(s2_hd_q) - (NumW'(s2_ym_q) <<< 1) + bias;
      s3_q.den    <= {s2_d_q, 1'b0};
    end
  end

  assign rdy3      = !s3_v_q || div_rdy;
  assign rdy2      = !s2_v_q || rdy3;
  assign rdy1      = !s1_v_q || rdy2;
  assign pt_in.ready = rdy1;

  logic     div_v;
  ppr_div_t div_q;

  ppr_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s3_v_q),
    .in_ready_o  (div_rdy),
    .in_data_i   (s3_q),
    .out_valid_o (div_v),
    .out_ready_i (rdy_out),
    .out_data_o  (div_q)
  );

  // output register: remove bias, clamp, blank points behind the camera
  logic       out_v_q;
  ppr_pixel_t out_q;
  ppr_pixel_t out_d;

  always_comb begin
    out_d.pixel_x       = div_q.lo_x ? PixMin : div_q.hi_x ? PixMax
                        : $signed({~div_q.qx[PixW-1], div_q.qx[PixW-2:0]});
    out_d.pixel_y       = div_q.lo_y ? PixMin : div_q.hi_y ? PixMax
                        : $signed({~div_q.qy[PixW-1], div_q.qy[PixW-2:0]});
    out_d.behind_camera = div_q.behind;
    out_d.saturated     = div_q.lo_x || div_q.hi_x || div_q.lo_y || div_q.hi_y;
    if (div_q.behind) begin
      out_d.pixel_x   = '0;
      out_d.pixel_y   = '0;
      out_d.saturated = 1'b0;
    end
  end

  assign rdy_out = !out_v_q || px_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy_out) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && div_v) begin
      out_q <= out_d;
    end
  end

  assign px_out.valid = out_v_q;
  assign px_out.data  = out_q;

  `ASSERT_IMPL(a_behind_zero, clk_i, rst_ni, out_v_q && out_q.behind_camera,
    out_q.pixel_x == '0 && out_q.pixel_y == '0 && !out_q.saturated)
  `ASSERT_IMPL(a_sat_edge, clk_i, rst_ni, out_v_q && out_q.saturated,
    out_q.pixel_x == PixMin || out_q.pixel_x == PixMax ||
    out_q.pixel_y == PixMin || out_q.pixel_y == PixMax)
  `ASSERT_NEXT(a_front_hold, clk_i, rst_ni, s3_v_q && !div_rdy,
    s3_v_q && $stable(s3_q))
endmodule

// File: tb/sv/perspective_point_to_raster_tb.sv
// Testbench for the perspective projection block: random and corner points checked against a model.
`timescale 1ns / 100ps
module perspective_point_to_raster_tb;
  import ppr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int Latency    = 21;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  ppr_point_if pt_ch ();
  ppr_pixel_if px_ch ();
  ppr_cfg_if   cfg_ch ();

  perspective_point_to_raster uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_in  (pt_ch.sink),
    .px_out (px_ch.source),
    .cfg    (cfg_ch.sink)
  );

  // shadow copy of the camera registers
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [12:0]        img_w, img_h;

  ppr_point_t point_q[$];   // words waiting for the driver
  ppr_pixel_t pixel_q[$];   // predicted pixel words, oldest first
  int  send_idle_pct = 26;
  int  recv_idle_pct = 61;
  bit  hold_off      = 1'b0;
  int  errors        = 0;
  int  cycles        = 0;

  // exact projection: floor of one rational per axis, then clamp to 16 bits
  function automatic ppr_pixel_t project(ppr_point_t p);
    ppr_pixel_t r;
    longint cx, cy, d, m, nx, ny, den, qx, qy;
    r = '0;
    cx = longint'(p.world_x) - longint'(cam_x);
    cy = longint'(p.world_y) - longint'(cam_y);
    d  = longint'(cam_z) - longint'(p.world_z);
    if (d <= 0) begin
      r.behind_camera = 1'b1;
      return r;
    end
    m   = (img_w < img_h) ? longint'(img_w) : longint'(img_h);
    den = 2 * d;
    nx  = 2 * cx * m + longint'(img_w) * d;
    ny  = longint'(img_h) * d - 2 * cy * m;
    qx  = nx / den;
    if (nx % den != 0 && nx < 0) qx -= 1;
    qy  = ny / den;
    if (ny % den != 0 && ny < 0) qy -= 1;
    if (qx < -32768) begin qx = -32768; r.saturated = 1'b1; end
    if (qx > 32767)  begin qx = 32767;  r.saturated = 1'b1; end
    if (qy < -32768) begin qy = -32768; r.saturated = 1'b1; end
    if (qy > 32767)  begin qy = 32767;  r.saturated = 1'b1; end
    r.pixel_x = qx[15:0];
    r.pixel_y = qy[15:0];
    return r;
  endfunction

  // driver: the prediction is made at acceptance, against the shadow copy of the registers
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (pt_ch.valid && pt_ch.ready) begin
        pixel_q.insert(pixel_q.size(), project(pt_ch.data));
        void'(point_q.pop_front());
      end
      if (pt_ch.valid && !pt_ch.ready) begin
        // word still waiting: hold it
      end else if (!hold_off && point_q.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        pt_ch.valid <= 1'b1;
        pt_ch.data  <= point_q[0];
      end else begin
        pt_ch.valid <= 1'b0;
      end
      px_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    ppr_pixel_t want;
    if (rst_ni && px_ch.valid && px_ch.ready) begin
      if (pixel_q.size() == 0) begin
        $error("pixel word with nothing expected");
        errors = errors + 1;
      end else begin
        want = pixel_q.pop_front();
        if (px_ch.data.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, px_ch.data.pixel_x);
          errors = errors + 1;
        end
        if (px_ch.data.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, px_ch.data.pixel_y);
          errors = errors + 1;
        end
        if (px_ch.data.behind_camera !== want.behind_camera) begin
          $error("behind_camera: expected %0b, got %0b", want.behind_camera,
                 px_ch.data.behind_camera);
          errors = errors + 1;
        end
        if (px_ch.data.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, px_ch.data.saturated);
          errors = errors + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one register write; only called with the pipeline empty
  task automatic write_reg(ppr_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_CAM_X: cam_x = val;
      REG_CAM_Y: cam_y = val;
      REG_CAM_Z: cam_z = val;
      REG_IMG_W: img_w = val[12:0];
      REG_IMG_H: img_h = val[12:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    wait (point_q.size() == 0 && !pt_ch.valid);
    wait (pixel_q.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic set_camera(logic [31:0] x, y, z, logic [12:0] w, h);
    drain();
    write_reg(REG_CAM_X, x);
    write_reg(REG_CAM_Y, y);
    write_reg(REG_CAM_Z, z);
    write_reg(REG_IMG_W, {19'd0, w});
    write_reg(REG_IMG_H, {19'd0, h});
  endtask

  function automatic ppr_point_t mk(logic [31:0] x, y, z);
    ppr_point_t p;
    p.world_x = x;
    p.world_y = y;
    p.world_z = z;
    return p;
  endfunction

  // append one word to the driver's queue
  task automatic queue_point(ppr_point_t p);
    point_q.insert(point_q.size(), p);
  endtask

  // mostly points in front of the camera in a sensible range, some anything
  function automatic ppr_point_t rand_point();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6)
      return mk($urandom_range(0, 2 ** 22) - 2 ** 21, $urandom_range(0, 2 ** 22) - 2 ** 21,
                cam_z - $urandom_range(1, 2 ** 22));
    if (sel < 8)
      return mk($urandom, $urandom, cam_z - $urandom_range(1, 2 ** 8));
    return mk($urandom, $urandom, $urandom);
  endfunction

  task automatic random_phase(int n);
    repeat (n) queue_point(rand_point());
  endtask

  initial begin
    pt_ch.valid  = 1'b0;
    pt_ch.data   = '0;
    px_ch.ready  = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    cam_x = '0; cam_y = '0; cam_z = '0;
    img_w = 13'd640; img_h = 13'd480;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners at the reset camera
    queue_point(mk(0, 0, -32'sd65536));                    // centre
    queue_point(mk(0, 0, 0));                               // on camera plane
    queue_point(mk(0, 0, 32'sd65536));                      // behind
    queue_point(mk(32'h7fffffff, 32'h80000000, -1));        // huge, saturates
    queue_point(mk(32'h80000000, 32'h7fffffff, -1));
    queue_point(mk(32'h80000000, 32'h80000000, 32'h80000000));
    queue_point(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    queue_point(mk(-32'sd1, -32'sd1, 32'h80000000));
    queue_point(mk(32'sd65536, -32'sd65536, -32'sd65536));
    queue_point(mk(32'hffffffff, 32'h00000001, -32'sd3));

    // camera at the extremes, odd and zero-sized images, over-range sizes
    set_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff, 13'd4096, 13'd1);
    queue_point(mk(32'h80000000, 32'h7fffffff, 32'h80000000));
    queue_point(mk(0, 0, 0));
    queue_point(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff));
    set_camera(32'h80000000, 32'h7fffffff, 32'h80000000, 13'd0, 13'd8191);
    queue_point(mk(0, 0, 32'h80000000));                    // depth zero
    queue_point(mk(32'h7fffffff, 32'h80000000, 32'h80000001));
    set_camera(32'sd1000, -32'sd1000, 32'sd65536, 13'd1, 13'd4096);
    queue_point(mk(32'sd1000, -32'sd1000, 0));
    queue_point(mk(32'sd70000, 32'sd0, -32'sd65536));

    // random: sender lean, receiver stalling hard
    set_camera(0, 0, 0, 13'd640, 13'd480);
    random_phase(400);
    // pause the sender until everything is back
    drain();
    hold_off = 1'b1;
    repeat (5) @(posedge clk_i);
    hold_off = 1'b0;
    send_idle_pct = 61;
    recv_idle_pct = 26;
    set_camera($urandom, $urandom, $urandom_range(0, 2 ** 24), 13'd7, 13'd4096);
    random_phase(400);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_camera($urandom, $urandom, $urandom, 13'($urandom_range(1, 4096)),
               13'($urandom_range(1, 4096)));
    random_phase(350);
    set_camera(0, 0, 0, 13'd3, 13'd2);
    random_phase(350);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
